// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and memory word types for the ARP cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENT_DEPTH = 32;
  localparam int REQ_DEPTH = 16;
  localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
  localparam int REQ_AW    = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
  localparam int ENT_CW    = $clog2(ENT_DEPTH + 1);
  localparam int REQ_CW    = $clog2(REQ_DEPTH + 1);
  localparam int SCAN_W    = (ENT_CW > REQ_CW) ? ENT_CW : REQ_CW;

  // operation codes
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_LOOKUP = 3'd1;
  localparam logic [2:0] FN_INSERT = 3'd2;
  localparam logic [2:0] FN_QUEUE  = 3'd3;
  localparam logic [2:0] FN_REMOVE = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // configuration register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_MAX_SENDS = 1'b1;

  localparam logic [14:0] TIMEOUT_RST   = 15'd30;
  localparam logic [7:0]  MAX_SENDS_RST = 8'd5;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] stamp;
  } ent_word_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] stamp;
    logic [7:0]  sends;
  } req_word_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic        request_pending;
    logic        resend;
    logic [31:0] resend_ip;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

// ===== sv/arp_cache_with_aging.sv =====
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// IP-to-MAC cache and pending request table with aging and request retry.
// ----------------------------------------------------------------------------
// Usage:
//  - Command: raise start with func/ip_addr/mac_in; taken when busy is low.
//  - Results: each one shows for a single cycle with valid high; last marks
//    the final result of a command. The receiver cannot stall.
//  - Config: cfg_we/cfg_addr/cfg_wdata write timeout_seconds (0) or
//    max_sends (1); write only while idle.
//  - Both tables live in memories with registered read data and are kept
//    packed in insertion order. Each scan reads one slot per cycle; tick and
//    remove scans rewrite survivors at a lower write index, compacting in place.
//  - Passes: clear and unused codes answer straight from idle with no scan.
//    Lookup runs the entry pass, insert/queue/remove the request pass, and
//    tick the request pass and then the entry pass; an empty table shortens
//    its pass. Resend results stream out during the request pass.
//    The single memory read port per table paces each pass; busy stays high
//    for the whole scan.
//  - Reset: time, both fill counts and the config registers return to defaults;
//    memory contents are not cleared (fill counts guard them).
// ----------------------------------------------------------------------------
module arp_cache_with_aging (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_in,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_wdata,
  output logic        valid,
  output logic        hit,
  output logic [47:0] mac_out,
  output logic        request_pending,
  output logic        resend,
  output logic [31:0] resend_ip,
  output logic [1:0]  status,
  output logic        last
);
  import arpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REQ  = 2'd1;
  localparam logic [1:0] S_ENT  = 2'd2;

  logic [1:0]        state;
  logic [2:0]        op;
  logic [31:0]       op_ip;
  logic [15:0]       now_time;
  logic [14:0]       timeout_seconds;
  logic [7:0]        max_sends;
  logic [ENT_CW-1:0] n_ent;
  logic [REQ_CW-1:0] n_req;
  logic [SCAN_W-1:0] rd_idx;
  logic [SCAN_W-1:0] wr_idx;
  logic              dv;
  logic              found;
  logic              ins_full;
  logic [47:0]       found_mac;

  ent_word_t ent_mem [ENT_DEPTH];
  req_word_t req_mem [REQ_DEPTH];
  ent_word_t ent_q;
  req_word_t req_q;

  logic              ent_we, req_we;
  logic [ENT_AW-1:0] ent_wa;
  logic [REQ_AW-1:0] req_wa;
  ent_word_t         ent_wd;
  req_word_t         req_wd;

  logic [SCAN_W-1:0] n_cur;
  logic              scanning, issue, scan_end;
  logic [15:0]       ent_age, req_age;
  logic              ent_due, req_due, req_drop, ent_match, req_match;
  logic              accept;
  logic              emit;
  result_t           res;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign n_cur    = (state == S_ENT) ? SCAN_W'(n_ent) : SCAN_W'(n_req);
  assign scanning = (state == S_REQ) || (state == S_ENT);
  assign issue    = scanning && (rd_idx < n_cur);
  assign scan_end = scanning && !issue && !dv;

  // ages wrap modulo 2^16, timeout compares zero-extended
  assign ent_age   = now_time - ent_q.stamp;
  assign req_age   = now_time - req_q.stamp;
  assign ent_due   = ent_age >= {1'b0, timeout_seconds};
  assign req_due   = req_age >= {1'b0, timeout_seconds};
  assign req_drop  = req_due && (req_q.sends >= max_sends);
  assign ent_match = ent_q.ip == op_ip;
  assign req_match = req_q.ip == op_ip;

  // memory write ports: compaction write-back, insert append, queue append
  always_comb begin
    ent_we = 1'b0;
    ent_wa = wr_idx[ENT_AW-1:0];
    ent_wd = ent_q;
    req_we = 1'b0;
    req_wa = wr_idx[REQ_AW-1:0];
    req_wd = req_q;
    if (accept && func == FN_INSERT && n_ent < ENT_CW'(ENT_DEPTH)) begin
      ent_we = 1'b1;
      ent_wa = n_ent[ENT_AW-1:0];
      ent_wd = '{ip: ip_addr, mac: mac_in, stamp: now_time};
    end
    if (state == S_ENT && dv && op == FN_TICK && !ent_due) begin
      ent_we = 1'b1;
    end
    if (state == S_REQ && dv) begin
      if (op == FN_TICK && !req_drop) begin
        req_we = 1'b1;
        if (req_due) begin
          req_wd.stamp = now_time;
          req_wd.sends = req_q.sends + 8'd1;
        end
      end else if (op == FN_REMOVE && (found || !req_match)) begin
        req_we = 1'b1;
      end
    end
    if (state == S_REQ && scan_end && op == FN_QUEUE && !found &&
        n_req < REQ_CW'(REQ_DEPTH)) begin
      req_we = 1'b1;
      req_wa = n_req[REQ_AW-1:0];
      req_wd = '{ip: op_ip, stamp: now_time - {1'b0, timeout_seconds}, sends: 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[rd_idx[ENT_AW-1:0]];
    if (req_we) req_mem[req_wa] <= req_wd;
    req_q <= req_mem[rd_idx[REQ_AW-1:0]];
  end

  // result selection
  always_comb begin
    emit = 1'b0;
    res  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && func != FN_TICK && func != FN_LOOKUP && func != FN_INSERT &&
            func != FN_QUEUE && func != FN_REMOVE) begin
          emit     = 1'b1;
          res.last = 1'b1;
        end
      end
      S_REQ: begin
        if (dv && op == FN_TICK && req_due && !req_drop) begin
          emit          = 1'b1;
          res.resend    = 1'b1;
          res.resend_ip = req_q.ip;
        end
        if (scan_end && op != FN_TICK) begin
          emit     = 1'b1;
          res.last = 1'b1;
          if (op == FN_REMOVE && !found) res.status = ST_NOTFOUND;
          if (op == FN_INSERT) begin
            res.request_pending = found;
            if (ins_full) res.status = ST_FULL;
          end
          if (op == FN_QUEUE && !found && n_req >= REQ_CW'(REQ_DEPTH)) res.status = ST_FULL;
        end
      end
      S_ENT: begin
        if (scan_end) begin
          emit     = 1'b1;
          res.last = 1'b1;
          if (op == FN_LOOKUP) begin
            res.hit     = found;
            res.mac_out = found_mac;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= 1'b0;
      dv              <= 1'b0;
      now_time        <= '0;
      n_ent           <= '0;
      n_req           <= '0;
      timeout_seconds <= TIMEOUT_RST;
      max_sends       <= MAX_SENDS_RST;
    end else begin
      valid <= emit;
      dv    <= issue;
      if (issue) rd_idx <= rd_idx + 1'b1;
      if (cfg_we) begin
        if (cfg_addr == CFG_TIMEOUT) timeout_seconds <= cfg_wdata;
        else                         max_sends       <= cfg_wdata[7:0];
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= func;
            op_ip     <= ip_addr;
            rd_idx    <= '0;
            wr_idx    <= '0;
            found     <= 1'b0;
            found_mac <= '0;
            ins_full  <= n_ent >= ENT_CW'(ENT_DEPTH);
            unique case (func)
              FN_TICK: begin
                now_time <= now_time + 16'd1;
                state    <= S_REQ;
              end
              FN_LOOKUP: state <= S_ENT;
              FN_INSERT: begin
                if (n_ent < ENT_CW'(ENT_DEPTH)) n_ent <= n_ent + 1'b1;
                state <= S_REQ;
              end
              FN_QUEUE, FN_REMOVE: state <= S_REQ;
              FN_CLEAR: begin
                n_ent <= '0;
                n_req <= '0;
              end
              default: ;
            endcase
          end
        end
        S_REQ: begin
          if (dv) begin
            if (op == FN_TICK) begin
              if (!req_drop) wr_idx <= wr_idx + 1'b1;
            end else if (op == FN_REMOVE) begin
              if (!found && req_match) found  <= 1'b1;
              else                     wr_idx <= wr_idx + 1'b1;
            end else if (req_match) begin
              found <= 1'b1;
            end
          end
          if (scan_end) begin
            if (op == FN_TICK) begin
              n_req  <= wr_idx[REQ_CW-1:0];
              rd_idx <= '0;
              wr_idx <= '0;
              state  <= S_ENT;
            end else begin
              if (op == FN_REMOVE) n_req <= wr_idx[REQ_CW-1:0];
              if (op == FN_QUEUE && !found && n_req < REQ_CW'(REQ_DEPTH))
                n_req <= n_req + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_ENT: begin
          if (dv) begin
            if (op == FN_TICK) begin
              if (!ent_due) wr_idx <= wr_idx + 1'b1;
            end else if (ent_match && !found) begin
              found     <= 1'b1;
              found_mac <= ent_q.mac;
            end
          end
          if (scan_end) begin
            if (op == FN_TICK) n_ent <= wr_idx[ENT_CW-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit             <= res.hit;
      mac_out         <= res.mac_out;
      request_pending <= res.request_pending;
      resend          <= res.resend;
      resend_ip       <= res.resend_ip;
      status          <= res.status;
      last            <= res.last;
    end
  end

endmodule
